[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the matcher checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define MTSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define MTSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mtsm_pkg.sv]
// ----------------------------------------------------------------------------
// mtsm_pkg
// Types, register map and helpers shared by the menu text matcher modules.
// ----------------------------------------------------------------------------
package mtsm_pkg;

    // APB register map (index = paddr[3:2])
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_PLEN     = 2'd1;
    localparam logic [1:0] REG_PAT_LOW  = 2'd2;
    localparam logic [1:0] REG_PAT_HIGH = 2'd3;

    // Search modes; the unused code behaves as prefix
    localparam logic [1:0] MODE_NEVER     = 2'd0;
    localparam logic [1:0] MODE_SUBSTRING = 2'd1;
    localparam logic [1:0] MODE_PREFIX    = 2'd2;

    localparam logic [1:0] MODE_RESET = MODE_PREFIX;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  plen;
        logic [31:0] pat_low;
        logic [31:0] pat_high;
    } cfg_t;

    typedef struct packed {
        logic        hit;
        logic [7:0]  pos;
        logic        shown;
        logic [10:0] count;
        logic        any_hit;
        logic        too_long;
    } res_t;

    // ASCII upper case to lower case, other bytes unchanged
    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

[rtl/core/mtsm_cfg.sv]
// ----------------------------------------------------------------------------
// mtsm_cfg
// APB register file holding search mode, pattern length and pattern bytes.
// ----------------------------------------------------------------------------
module mtsm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mtsm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output mtsm_pkg::cfg_t              cfg
);
    import mtsm_pkg::*;

    logic [1:0]  mode_reg;
    logic [3:0]  plen_reg;
    logic [31:0] pat_low_reg;
    logic [31:0] pat_high_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RESET;
            plen_reg     <= 4'd0;
            pat_low_reg  <= 32'd0;
            pat_high_reg <= 32'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_MODE:     mode_reg     <= pwdata[1:0];
                REG_PLEN:     plen_reg     <= pwdata[3:0];
                REG_PAT_LOW:  pat_low_reg  <= pwdata;
                REG_PAT_HIGH: pat_high_reg <= pwdata;
                default:      mode_reg     <= mode_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_sel)
            REG_MODE:     prdata = {30'd0, mode_reg};
            REG_PLEN:     prdata = {28'd0, plen_reg};
            REG_PAT_LOW:  prdata = pat_low_reg;
            REG_PAT_HIGH: prdata = pat_high_reg;
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.mode     = mode_reg;
    assign cfg.plen     = plen_reg;
    assign cfg.pat_low  = pat_low_reg;
    assign cfg.pat_high = pat_high_reg;

endmodule

[rtl/core/mtsm_match.sv]
// ----------------------------------------------------------------------------
// mtsm_match
// Per-item match state: sliding byte window, parallel pattern compare,
// prefix tracking and the enabled-hit tally. Produces the item result.
// ----------------------------------------------------------------------------
module mtsm_match #(
    parameter int PATTERN_MAX    = 8,
    parameter int TEXT_MAX       = 256,
    parameter int ITEM_COUNT_MAX = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mtsm_pkg::cfg_t cfg,
    input  logic           step_en,
    input  logic [7:0]     text_byte,
    input  logic           byte_present,
    input  logic           item_enabled,
    input  logic           last_of_item,
    input  logic           last_of_menu,
    output mtsm_pkg::res_t res
);
    import mtsm_pkg::*;

    localparam int IW  = $clog2(TEXT_MAX + 2);
    localparam int PLW = $clog2(PATTERN_MAX + 1);
    localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int TW  = $clog2(ITEM_COUNT_MAX + 1);
    localparam int CW  = (TW > 11) ? TW : 11;

    logic [7:0]    recent_reg [PATTERN_MAX];
    logic [7:0]    recent_next [PATTERN_MAX];
    logic [IW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [7:0]    fpos_reg, fpos_next;
    logic          pre_ok_reg, pre_ok_next;
    logic [TW-1:0] tally_reg, tally_next;
    logic          any_reg, any_next;

    logic [7:0]     pat [PATTERN_MAX];
    logic [7:0]     win [PATTERN_MAX];
    logic           cand [PATTERN_MAX+1];
    logic [PLW-1:0] plen_sat;
    logic [7:0]     b;
    logic           take_byte;
    logic           in_range;
    logic           reach;
    logic           hit;
    logic           too_long;
    logic [TW-1:0]  tally_inc;
    logic [CW-1:0]  tally_ext;

    // Pattern length clamp and folded pattern bytes
    assign plen_sat = ({1'b0, cfg.plen} > 5'(PATTERN_MAX)) ? PLW'(PATTERN_MAX)
                                                           : PLW'(cfg.plen);
    always_comb
    begin
        for (int p = 0; p < PATTERN_MAX; p++)
        begin
            if (p < 4)
                pat[p] = fold(cfg.pat_low[8*p +: 8]);
            else if (p < 8)
                pat[p] = fold(cfg.pat_high[8*(p-4) +: 8]);
            else
                pat[p] = 8'd0;
        end
    end

    assign b        = fold(text_byte);
    assign in_range = (idx_reg < IW'(TEXT_MAX));
    assign take_byte = byte_present && in_range;

    // Window: current byte then the most recent ones
    always_comb
    begin
        win[0] = b;
        for (int k = 1; k < PATTERN_MAX; k++)
            win[k] = recent_reg[k-1];
    end

    // One candidate compare per possible pattern length
    always_comb
    begin
        cand[0] = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            cand[l] = 1'b1;
            for (int p = 0; p < PATTERN_MAX; p++)
            begin
                if (p < l)
                begin
                    if (win[l-1-p] != pat[p])
                        cand[l] = 1'b0;
                end
            end
        end
    end

    assign reach = (({1'b0, idx_reg} + (IW+1)'(1)) >= (IW+1)'(plen_sat));

    // Per-byte state update
    always_comb
    begin
        idx_next    = idx_reg;
        found_next  = found_reg;
        fpos_next   = fpos_reg;
        pre_ok_next = pre_ok_reg;
        for (int k = 0; k < PATTERN_MAX; k++)
            recent_next[k] = recent_reg[k];
        if (byte_present && !in_range)
        begin
            idx_next = IW'(TEXT_MAX + 1);
        end
        else if (take_byte)
        begin
            if (idx_reg < IW'(plen_sat) && b != pat[idx_reg[PIW-1:0]])
                pre_ok_next = 1'b0;
            if (plen_sat != '0 && !found_reg && reach && cand[plen_sat])
            begin
                found_next = 1'b1;
                fpos_next  = 8'({1'b0, idx_reg} + (IW+1)'(1) - (IW+1)'(plen_sat));
            end
            for (int k = PATTERN_MAX - 1; k > 0; k--)
                recent_next[k] = recent_reg[k-1];
            recent_next[0] = b;
            idx_next = idx_reg + IW'(1);
        end
    end

    // Item-end decision on the updated state
    assign too_long = (idx_next > IW'(TEXT_MAX));
    always_comb
    begin
        unique case (cfg.mode)
            MODE_NEVER:     hit = 1'b0;
            MODE_SUBSTRING: hit = (plen_sat == '0) || found_next;
            default:        hit = (plen_sat != '0) && (idx_next != '0) && pre_ok_next;
        endcase
    end

    assign tally_inc = (hit && item_enabled && tally_reg < TW'(ITEM_COUNT_MAX))
                       ? tally_reg + TW'(1) : tally_reg;
    assign tally_ext = CW'(tally_inc);

    assign res.hit      = hit;
    assign res.pos      = (hit && cfg.mode == MODE_SUBSTRING && plen_sat != '0)
                          ? fpos_next : 8'd0;
    assign res.shown    = hit || (plen_sat == '0);
    assign res.count    = tally_ext[10:0];
    assign res.any_hit  = any_reg || (hit && item_enabled);
    assign res.too_long = too_long;

    // Tally, cleared after the last item of a menu
    always_comb
    begin
        tally_next = tally_reg;
        any_next   = any_reg;
        if (last_of_item)
        begin
            tally_next = last_of_menu ? '0 : tally_inc;
            any_next   = last_of_menu ? 1'b0 : res.any_hit;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
                recent_reg[k] <= 8'd0;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            fpos_reg   <= 8'd0;
            pre_ok_reg <= 1'b1;
            tally_reg  <= '0;
            any_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            tally_reg <= tally_next;
            any_reg   <= any_next;
            if (last_of_item)
            begin
                for (int k = 0; k < PATTERN_MAX; k++)
                    recent_reg[k] <= 8'd0;
                idx_reg    <= '0;
                found_reg  <= 1'b0;
                fpos_reg   <= 8'd0;
                pre_ok_reg <= 1'b1;
            end
            else
            begin
                for (int k = 0; k < PATTERN_MAX; k++)
                    recent_reg[k] <= recent_next[k];
                idx_reg    <= idx_next;
                found_reg  <= found_next;
                fpos_reg   <= fpos_next;
                pre_ok_reg <= pre_ok_next;
            end
        end
    end

endmodule

[rtl/core/menu_text_search_matcher.sv]
// ----------------------------------------------------------------------------
// menu_text_search_matcher
// Case-insensitive substring / prefix matcher for streamed menu item texts.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one text byte per beat; tlast closes an item and
//   tuser flags byte presence, item enable and menu end. An item with no text
//   is one beat with byte_present low and tlast high.
//   One result beat leaves on the master stream for each item, once the beat
//   that closes it has passed the input register and then the result register.
//   Throughput is one byte per cycle while the result stream does not stall:
//   each byte is checked against the whole pattern by a parallel window compare.
//   Pattern and mode must be written over APB only while the stream is idle;
//   the block itself does not enforce this. Reset clears the item state and
//   the hit tally; mode resets to prefix, pattern length to zero.
//   When the receiver stalls, the result holds in the output register and an
//   input beat is taken only if the input register is empty; then s_tready drops.
//   Bytes past TEXT_MAX are dropped and flagged in the item's result.
// ----------------------------------------------------------------------------
module menu_text_search_matcher #(
    parameter int PATTERN_MAX    = 8,
    parameter int TEXT_MAX       = 256,
    parameter int ITEM_COUNT_MAX = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mtsm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // text byte stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] text_byte
    input  logic [2:0]                  s_tuser,  // [0] byte_present [1] item_enabled
                                                  // [2] last_of_menu
    input  logic                        s_tlast,  // last_of_item
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,  // [7:0] match_position
                                                  // [18:8] enabled_hit_count
    output logic [3:0]                  m_tuser   // [0] hit [1] shown
                                                  // [2] any_enabled_hit [3] text_too_long
);
    import mtsm_pkg::*;

    cfg_t       cfg;
    res_t       res;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [2:0] in_user_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    res_t       out_reg;
    logic       advance;
    logic       step_en;

    mtsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline moves when the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_user_reg <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    mtsm_match #(
        .PATTERN_MAX    (PATTERN_MAX),
        .TEXT_MAX       (TEXT_MAX),
        .ITEM_COUNT_MAX (ITEM_COUNT_MAX)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step_en      (step_en),
        .text_byte    (in_byte_reg),
        .byte_present (in_user_reg[0]),
        .item_enabled (in_user_reg[1]),
        .last_of_item (in_last_reg),
        .last_of_menu (in_user_reg[2]),
        .res          (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step_en && in_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en && in_last_reg)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.count, out_reg.pos};
    assign m_tuser  = {out_reg.too_long, out_reg.any_hit, out_reg.shown, out_reg.hit};

endmodule

[rtl/core/mtsm_checker.sv]
// ----------------------------------------------------------------------------
// mtsm_checker
// Port-level checks on the matcher result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // A hit item is always shown
    `MTSM_ASSERT(a_hit_shown, m_tvalid |-> (!m_tuser[0] || m_tuser[1]), "hit without shown")

    // No hit means no match position
    `MTSM_ASSERT(a_pos_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'd0), "position without hit")

    // Tally is nonzero exactly when some enabled item has hit
    `MTSM_ASSERT(a_tally_any, m_tvalid |-> ((m_tdata[18:8] == 11'd0) == !m_tuser[2]), "tally and any-hit disagree")

    // A stalled result beat stays put
    `MTSM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

endmodule

bind menu_text_search_matcher mtsm_checker u_mtsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for menu_text_search_matcher. Text beats go in on the
// slave stream and pattern/mode writes go in over APB. A local predictor works
// out every item's result, and each result beat is checked field by field.
// ----------------------------------------------------------------------------
module tb;
    import mtsm_pkg::*;

    localparam int TEXT_LIMIT    = 256;
    localparam int PAT_SLOTS     = 8;
    localparam int TALLY_MAX     = 1024;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 80;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_BEATS  = 240;

    // unused mode code, handled like prefix mode
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;  // [7:0] text_byte
    logic [2:0]          s_tuser;  // [0] byte_present [1] item_enabled [2] last_of_menu
    logic                s_tlast;  // last_of_item
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;  // [7:0] match_position [18:8] enabled_hit_count
    logic [3:0]          m_tuser;  // [0] hit [1] shown [2] any_enabled_hit [3] text_too_long

    // bench bookkeeping
    int fails;
    int quiet_cycles;
    int beats_sent;
    int gap_pct;
    int stall_pct;
    bit hold_results;

    // predictor state
    cfg_t        cfg_shadow;
    logic [7:0]  window [PAT_SLOTS];
    int unsigned text_count;
    bit          found;
    int unsigned found_at;
    bit          prefix_ok;
    int unsigned menu_hits;
    bit          menu_any_hit;
    res_t        pending_matches [$];

    menu_text_search_matcher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] lower_ascii(input logic [7:0] b);
        if (b >= "A" && b <= "Z")
        begin
            return b | 8'h20;
        end
        return b;
    endfunction

    function automatic logic [7:0] pattern_raw(input int unsigned p);
        if (p < 4)
        begin
            return cfg_shadow.pat_low[8 * p +: 8];
        end
        if (p < 8)
        begin
            return cfg_shadow.pat_high[8 * (p - 4) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] pattern_char(input int unsigned p);
        return lower_ascii(pattern_raw(p));
    endfunction

    task automatic clear_text_state();
        int k;
        for (k = 0; k < PAT_SLOTS; k++)
        begin
            window[k] = 8'h00;
        end
        text_count = 0;
        found      = 1'b0;
        found_at   = 0;
        prefix_ok  = 1'b1;
    endtask

    // one accepted text beat; queues a result when it closes an item
    task automatic predict_match(input logic [7:0] raw, input bit present, input bit enabled,
                                 input bit item_end, input bit menu_end);
        int unsigned plen;
        int unsigned tlen;
        int unsigned pos;
        int          p;
        logic [7:0]  b;
        bit          eq;
        bit          hit;
        bit          too_long;
        res_t        r;

        plen = (cfg_shadow.plen > PAT_SLOTS) ? PAT_SLOTS : cfg_shadow.plen;
        if (present)
        begin
            if (text_count < TEXT_LIMIT)
            begin
                b = lower_ascii(raw);
                if (text_count < plen && b != pattern_char(text_count))
                begin
                    prefix_ok = 1'b0;
                end
                // window compare: newest byte against the last pattern char
                if (plen > 0 && !found && text_count + 1 >= plen)
                begin
                    eq = (b == pattern_char(plen - 1));
                    for (p = 0; p + 1 < plen; p++)
                    begin
                        if (window[plen - 2 - p] != pattern_char(p))
                        begin
                            eq = 1'b0;
                        end
                    end
                    if (eq)
                    begin
                        found    = 1'b1;
                        found_at = text_count + 1 - plen;
                    end
                end
                for (p = PAT_SLOTS - 1; p > 0; p--)
                begin
                    window[p] = window[p - 1];
                end
                window[0]  = b;
                text_count = text_count + 1;
            end
            else
            begin
                text_count = TEXT_LIMIT + 1;
            end
        end
        if (!item_end)
        begin
            return;
        end

        too_long = (text_count > TEXT_LIMIT);
        tlen     = too_long ? TEXT_LIMIT : text_count;
        hit      = 1'b0;
        pos      = 0;
        if (cfg_shadow.mode == MODE_NEVER)
        begin
            hit = 1'b0;
        end
        else if (cfg_shadow.mode == MODE_SUBSTRING)
        begin
            if (plen == 0)
            begin
                hit = 1'b1;
            end
            else if (found)
            begin
                hit = 1'b1;
                pos = found_at;
            end
        end
        else
        begin
            hit = (plen > 0) && (tlen > 0) && prefix_ok;
        end

        if (hit && enabled)
        begin
            if (menu_hits < TALLY_MAX)
            begin
                menu_hits++;
            end
            menu_any_hit = 1'b1;
        end

        r.hit      = hit;
        r.pos      = pos[7:0];
        r.shown    = hit || (plen == 0);
        r.count    = menu_hits[10:0];
        r.any_hit  = menu_any_hit;
        r.too_long = too_long;
        pending_matches.insert(pending_matches.size(), r);

        clear_text_state();
        if (menu_end)
        begin
            menu_hits    = 0;
            menu_any_hit = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        res_t want;
        if (pending_matches.size() == 0)
        begin
            $error("result beat with no item waiting for it");
            fails++;
            return;
        end
        want = pending_matches.pop_front();
        check_field("hit", 32'(want.hit), 32'(m_tuser[0]));
        check_field("match_position", 32'(want.pos), 32'(m_tdata[7:0]));
        check_field("shown", 32'(want.shown), 32'(m_tuser[1]));
        check_field("enabled_hit_count", 32'(want.count), 32'(m_tdata[18:8]));
        check_field("any_enabled_hit", 32'(want.any_hit), 32'(m_tuser[2]));
        check_field("text_too_long", 32'(want.too_long), 32'(m_tuser[3]));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            if (s_tvalid && s_tready)
            begin
                predict_match(s_tdata, s_tuser[0], s_tuser[1], s_tlast, s_tuser[2]);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if ($urandom_range(9) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // result side: random stalls, plus one long hold on request
    initial
    begin : receiver
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
                m_tready <= 1'b1;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(99) < stall_pct)
            begin
                m_tready <= 1'b0;
                stall = pick_gap() - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // append one byte to a text under construction
    task automatic add_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endtask

    task automatic send_beat(input logic [7:0] data, input bit present, input bit enabled,
                             input bit item_end, input bit menu_end);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {menu_end, enabled, present};
        s_tlast  <= item_end;
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    // one item; noisy adds missing bytes, stray menu ends and a byteless close
    task automatic send_item(input logic [7:0] txt[$], input bit enabled, input bit menu_end,
                             input bit noisy);
        int last;
        int i;
        bit trailer;
        trailer = noisy && ($urandom_range(9) == 0);
        if (txt.size() == 0)
        begin
            send_beat(8'($urandom_range(255)), 1'b0, enabled, 1'b1, menu_end);
            return;
        end
        last = txt.size() - 1;
        for (i = 0; i <= last; i++)
        begin
            if (noisy && $urandom_range(19) == 0)
            begin
                send_beat(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0,
                          1'($urandom_range(1)));
            end
            if (i == last && !trailer)
            begin
                send_beat(txt[i], 1'b1, enabled, 1'b1, menu_end);
            end
            else
            begin
                send_beat(txt[i], 1'b1, noisy ? 1'($urandom_range(1)) : enabled, 1'b0,
                          noisy && ($urandom_range(15) == 0));
            end
        end
        if (trailer)
        begin
            send_beat(8'($urandom_range(255)), 1'b0, enabled, 1'b1, menu_end);
        end
    endtask

    task automatic send_str(input string s, input bit enabled, input bit menu_end);
        logic [7:0] txt[$];
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            add_byte(txt, s[i]);
        end
        send_item(txt, enabled, menu_end, 1'b0);
    endtask

    function automatic logic [31:0] chars4(input string s);
        logic [31:0] w;
        int i;
        w = '0;
        for (i = 0; i < 4 && i < s.len(); i++)
        begin
            w[8 * i +: 8] = s[i];
        end
        return w;
    endfunction

    function automatic logic [7:0] vary_case(input logic [7:0] b);
        if (((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) && $urandom_range(1))
        begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 70)
        begin
            return vary_case(8'(8'h61 + $urandom_range(25)));
        end
        if (r < 85)
        begin
            return ($urandom_range(3) == 0) ? 8'h20 : 8'(8'h30 + $urandom_range(9));
        end
        return 8'($urandom_range(255));
    endfunction

    // near misses: about half of them chars taken from the pattern
    function automatic logic [7:0] filler_byte(input int unsigned plen);
        if (plen > 0 && $urandom_range(9) < 5)
        begin
            return vary_case(pattern_raw($urandom_range(0, plen - 1)));
        end
        return random_text_byte();
    endfunction

    // stop offering and wait until every expected result is back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_MODE:     cfg_shadow.mode     = value[1:0];
            REG_PLEN:     cfg_shadow.plen     = value[3:0];
            REG_PAT_LOW:  cfg_shadow.pat_low  = value;
            REG_PAT_HIGH: cfg_shadow.pat_high = value;
            default:      ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // reset values: prefix mode with an empty pattern never hits but shows
    task automatic test_reset_state();
        send_str("Ab", 1'b1, 1'b0);
        send_str("", 1'b1, 1'b1);
    endtask

    task automatic test_substring();
        drain();
        write_reg(REG_MODE, 32'(MODE_SUBSTRING));
        write_reg(REG_PLEN, 4);
        write_reg(REG_PAT_LOW, chars4("MeNu"));
        write_reg(REG_PAT_HIGH, 32'hFFFF_FFFF);
        send_str("xMENU", 1'b1, 1'b0);
        send_str("men", 1'b1, 1'b0);
        send_str("menumenu", 1'b0, 1'b0);
        send_str("", 1'b1, 1'b0);
        // missing byte and a stray menu end inside one item
        send_beat("m", 1'b1, 1'b0, 1'b0, 1'b0);
        send_beat("E", 1'b1, 1'b0, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0);
        send_beat("n", 1'b1, 1'b0, 1'b0, 1'b0);
        send_beat("U", 1'b1, 1'b1, 1'b1, 1'b0);
        send_str("open menu", 1'b1, 1'b1);
    endtask

    task automatic test_prefix_and_never();
        drain();
        write_reg(REG_MODE, 32'(MODE_PREFIX));
        send_str("ME", 1'b1, 1'b0);
        send_str("menus", 1'b1, 1'b0);
        send_str("amenu", 1'b1, 1'b0);
        send_str("", 1'b1, 1'b0);
        drain();
        write_reg(REG_MODE, 32'(MODE_SPARE));
        send_str("Menu!", 1'b1, 1'b0);
        drain();
        write_reg(REG_MODE, 32'(MODE_NEVER));
        send_str("menu", 1'b1, 1'b1);
    endtask

    task automatic test_empty_pattern();
        drain();
        write_reg(REG_PLEN, 0);
        send_str("abc", 1'b1, 1'b0);
        drain();
        write_reg(REG_MODE, 32'(MODE_SUBSTRING));
        send_str("", 1'b1, 1'b0);
        send_str("abc", 1'b1, 1'b1);
    endtask

    // length 15 saturates to 8; high bytes other than 5A (Z) are not letters and are not folded
    task automatic test_full_pattern();
        logic [7:0] txt[$];
        drain();
        write_reg(REG_PLEN, 15);
        write_reg(REG_PAT_LOW, chars4("aBcD"));
        write_reg(REG_PAT_HIGH, 32'h5AFF_00C1);
        txt = '{"x", "x", "A", "b", "C", "d", 8'hC1, 8'h00, 8'hFF, "z"};
        send_item(txt, 1'b1, 1'b0, 1'b0);
        txt[6] = 8'hE1;
        send_item(txt, 1'b1, 1'b0, 1'b0);
        drain();
        write_reg(REG_MODE, 32'(MODE_PREFIX));
        txt = '{"A", "B", "c", "d", 8'hC1};
        send_item(txt, 1'b1, 1'b1, 1'b0);
    endtask

    // registers rewritten while an item is half sent
    task automatic test_midstream_config();
        drain();
        write_reg(REG_MODE, 32'(MODE_SUBSTRING));
        write_reg(REG_PLEN, 3);
        write_reg(REG_PAT_LOW, chars4("abc"));
        send_beat("x", 1'b1, 1'b1, 1'b0, 1'b0);
        send_beat("a", 1'b1, 1'b1, 1'b0, 1'b0);
        send_beat("b", 1'b1, 1'b1, 1'b0, 1'b0);
        drain();
        write_reg(REG_PLEN, 2);
        write_reg(REG_PAT_LOW, chars4("bc"));
        send_beat("c", 1'b1, 1'b1, 1'b1, 1'b0);
        drain();
        write_reg(REG_MODE, 32'(MODE_PREFIX));
        write_reg(REG_PAT_LOW, chars4("ab"));
        send_beat("A", 1'b1, 1'b1, 1'b0, 1'b0);
        drain();
        write_reg(REG_PAT_LOW, chars4("zb"));
        send_beat("b", 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    // texts at and past the length limit
    task automatic test_long_text();
        logic [7:0] txt[$];
        int i;
        drain();
        write_reg(REG_MODE, 32'(MODE_SUBSTRING));
        write_reg(REG_PLEN, 3);
        write_reg(REG_PAT_LOW, chars4("end"));
        for (i = 0; i < 253; i++)
        begin
            add_byte(txt, "x");
        end
        add_byte(txt, "E");
        add_byte(txt, "n");
        add_byte(txt, "D");
        send_item(txt, 1'b1, 1'b0, 1'b0);
        txt.delete();
        for (i = 0; i < 254; i++)
        begin
            add_byte(txt, "x");
        end
        add_byte(txt, "e");
        add_byte(txt, "n");
        add_byte(txt, "d");
        for (i = 0; i < 6; i++)
        begin
            add_byte(txt, "q");
        end
        send_item(txt, 1'b1, 1'b1, 1'b0);
    endtask

    // enabled hits without a menu end until the tally saturates
    task automatic test_tally_saturation();
        int i;
        drain();
        write_reg(REG_MODE, 32'(MODE_SUBSTRING));
        write_reg(REG_PLEN, 0);
        gap_pct   = 0;
        stall_pct = 0;
        for (i = 0; i < TALLY_MAX + 6; i++)
        begin
            send_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
        end
        send_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
        gap_pct   = 20;
        stall_pct = 20;
    endtask

    // long receiver hold while items keep coming, then a full pause
    task automatic test_backpressure();
        int i;
        drain();
        write_reg(REG_MODE, 32'(MODE_PREFIX));
        write_reg(REG_PLEN, 2);
        write_reg(REG_PAT_LOW, chars4("ab"));
        gap_pct      = 0;
        hold_results = 1'b1;
        for (i = 0; i < 40; i++)
        begin
            send_str((i % 3 == 0) ? "Ab" : "b", i[0], i == 39);
        end
        drain();
        gap_pct = 20;
    endtask

    task automatic test_random_menus();
        logic [7:0]  txt[$];
        logic [31:0] chars [2];
        int          stop_at;
        int          plen;
        int          r;
        int          i;
        int          cut;

        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at)
        begin
            drain();
            r = $urandom_range(99);
            write_reg(REG_MODE, 32'((r < 8) ? MODE_NEVER : (r < 50) ? MODE_SUBSTRING :
                                    (r < 90) ? MODE_PREFIX : MODE_SPARE));
            r = $urandom_range(99);
            write_reg(REG_PLEN, (r < 8) ? 0 : (r < 16) ? $urandom_range(9, 15) :
                                $urandom_range(1, 8));
            for (i = 0; i < 8; i++)
            begin
                chars[i / 4][8 * (i % 4) +: 8] = random_text_byte();
            end
            write_reg(REG_PAT_LOW, chars[0]);
            write_reg(REG_PAT_HIGH, chars[1]);
            plen = (cfg_shadow.plen > PAT_SLOTS) ? PAT_SLOTS : cfg_shadow.plen;

            r         = $urandom_range(2);
            gap_pct   = (r == 0) ? 0 : (r == 1) ? 15 : 40;
            r         = $urandom_range(2);
            stall_pct = (r == 0) ? 0 : (r == 1) ? 15 : 40;

            // items: filler, then often the pattern (maybe cut short), then filler
            repeat ($urandom_range(8, 20))
            begin
                txt.delete();
                r = $urandom_range(99);
                if (r == 0)
                begin
                    repeat ($urandom_range(248, 262)) add_byte(txt, filler_byte(plen));
                end
                else if ($urandom_range(1))
                begin
                    repeat ($urandom_range(1, 5)) add_byte(txt, filler_byte(plen));
                end
                if (r < 70)
                begin
                    cut = (r < 12) ? $urandom_range(0, plen) : plen;
                    for (i = 0; i < cut; i++)
                    begin
                        add_byte(txt, vary_case(pattern_raw(i)));
                    end
                end
                repeat ($urandom_range(0, 4)) add_byte(txt, filler_byte(plen));
                send_item(txt, 1'($urandom_range(1)), $urandom_range(5) == 0, 1'b1);
            end
        end
        gap_pct   = 20;
        stall_pct = 20;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tuser      = 3'b000;
        s_tlast      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = 32'h0;
        fails        = 0;
        quiet_cycles = 0;
        beats_sent   = 0;
        gap_pct      = 20;
        stall_pct    = 20;
        hold_results = 1'b0;

        cfg_shadow.mode     = MODE_RESET;
        cfg_shadow.plen     = 4'd0;
        cfg_shadow.pat_low  = 32'h0;
        cfg_shadow.pat_high = 32'h0;
        clear_text_state();
        menu_hits    = 0;
        menu_any_hit = 1'b0;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_substring();
        test_prefix_and_never();
        test_empty_pattern();
        test_full_pattern();
        test_midstream_config();
        test_long_text();
        test_tally_saturation();
        test_backpressure();
        test_random_menus();
        drain();

        if (fails == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
